// ----- rtl/glim_pkg.sv -----
// glim_pkg: field widths, command and status codes, and the control and
// status structs shared by the grouped list index mapper modules.
// No dependencies.
`default_nettype none

package glim_pkg;

    // Item field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 17;
    localparam int START_W  = 16;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 2;
    localparam int GROUP_W  = 6;
    localparam int DISP_W   = 17;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_BEGIN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAP_DISP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MAP_SRC  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // run a non-search command, write result
        logic s_init;    // start a binary search
        logic s_read;    // read the table at the search midpoint
        logic s_step;    // compare and narrow the search window
        logic s_finish;  // form the query result from the search
        logic out_load;  // move the result into the output register
    } glim_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_search;  // captured item is an in-range query on a non-empty table
        logic s_done;       // search window is empty
        logic out_free;     // output register can take a result this cycle
    } glim_sts_t;

endpackage

`default_nettype wire

// ----- rtl/glim_in_if.sv -----
// glim_in_if: request channel, valid/ready plus one command item.
// Depends on glim_pkg for field widths.
`default_nettype none

interface glim_in_if;
    logic                         valid;
    logic                         ready;
    logic [glim_pkg::CMD_W-1:0]   command;
    logic [glim_pkg::IDX_W-1:0]   index;
    logic [glim_pkg::START_W-1:0] section_start;
    logic [glim_pkg::COUNT_W-1:0] section_count;

    modport source (output valid, command, index, section_start, section_count,
                    input ready);
    modport sink   (input valid, command, index, section_start, section_count,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/glim_out_if.sv -----
// glim_out_if: response channel, valid/ready plus one result item.
// Depends on glim_pkg for field widths.
`default_nettype none

interface glim_out_if;
    logic                          valid;
    logic                          ready;
    logic [glim_pkg::STATUS_W-1:0] status;
    logic                          is_header;
    logic [glim_pkg::START_W-1:0]  source_row;
    logic [glim_pkg::GROUP_W-1:0]  group_number;
    logic [glim_pkg::DISP_W-1:0]   display_position;

    modport source (output valid, status, is_header, source_row, group_number,
                    display_position, input ready);
    modport sink   (input valid, status, is_header, source_row, group_number,
                    display_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/glim_ctrl.sv -----
// glim_ctrl: sequencer for one item at a time: capture, execute or
// binary search, then hand the result to the output register.
// Depends on glim_pkg for the control and status structs.
`default_nettype none

module glim_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire glim_pkg::glim_sts_t sts,
    output glim_pkg::glim_ctl_t      ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_valid) state_next = S_EXEC;
            S_EXEC: state_next = sts.need_search ? S_READ : S_DONE;
            S_READ: state_next = sts.s_done ? S_DONE : S_CMP;
            S_CMP:  state_next = S_READ;
            S_DONE: if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = ready_reg;

    // Datapath strobes
    always_comb
    begin
        ctl          = '0;
        ctl.capture  = ready_reg && req_valid;
        ctl.exec     = (state_reg == S_EXEC) && !sts.need_search;
        ctl.s_init   = (state_reg == S_EXEC) && sts.need_search;
        ctl.s_read   = (state_reg == S_READ) && !sts.s_done;
        ctl.s_finish = (state_reg == S_READ) && sts.s_done;
        ctl.s_step   = (state_reg == S_CMP);
        ctl.out_load = (state_reg == S_DONE) && sts.out_free;
    end

endmodule

`default_nettype wire

// ----- rtl/glim_dp.sv -----
// glim_dp: section table (two banks in one memory), staging checks,
// binary search window, result and output registers.
// Depends on glim_pkg and glim_out_if.
`default_nettype none

module glim_dp #(
    parameter int MAX_SECTIONS = 64,
    parameter int MAX_ROWS     = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [glim_pkg::CMD_W-1:0]   req_command,
    input  wire logic [glim_pkg::IDX_W-1:0]   req_index,
    input  wire logic [glim_pkg::START_W-1:0] req_start,
    input  wire logic [glim_pkg::COUNT_W-1:0] req_count,
    input  wire glim_pkg::glim_ctl_t          ctl,
    output glim_pkg::glim_sts_t               sts,
    glim_out_if.source                        response
);

    localparam int IDX_W   = glim_pkg::IDX_W;
    localparam int START_W = glim_pkg::START_W;
    localparam int SEC_W   = $clog2(MAX_SECTIONS + 1);
    localparam int SLOT_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int DEPTH   = 2 * MAX_SECTIONS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Captured item
    logic [glim_pkg::CMD_W-1:0]   cmd_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [START_W-1:0]           sstart_reg;
    logic [glim_pkg::COUNT_W-1:0] scount_reg;

    // Table and staging state
    logic             active_bank_reg;
    logic [IDX_W-1:0] active_total_reg;
    logic [SEC_W-1:0] active_n_reg;
    logic [IDX_W-1:0] staged_total_reg;
    logic [SEC_W-1:0] staged_n_reg;
    logic [IDX_W-1:0] expect_reg;
    logic             failed_reg;

    // Section start memory, bank b at b*MAX_SECTIONS
    logic [START_W-1:0] mem [DEPTH];
    logic [START_W-1:0] rd_data_reg;

    // Search window
    logic [SEC_W-1:0]   lo_reg;
    logic [SEC_W-1:0]   hi_reg;
    logic [START_W-1:0] st_reg;

    // Result and output registers
    logic [glim_pkg::STATUS_W-1:0] res_status_reg;
    logic                          res_hdr_reg;
    logic [START_W-1:0]            res_src_reg;
    logic [glim_pkg::GROUP_W-1:0]  res_grp_reg;
    logic [glim_pkg::DISP_W-1:0]   res_disp_reg;
    logic                          out_valid_reg;
    logic [glim_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_hdr_reg;
    logic [START_W-1:0]            out_src_reg;
    logic [glim_pkg::GROUP_W-1:0]  out_grp_reg;
    logic [glim_pkg::DISP_W-1:0]   out_disp_reg;

    logic [IDX_W:0]       disp_limit;
    logic                 disp_range;
    logic                 src_range;
    logic                 n_zero;
    logic                 load_bad;
    logic                 commit_bad;
    logic [SEC_W:0]       mid_sum;
    logic [SEC_W-1:0]     mid;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 pred;
    logic [SEC_W-1:0]     g;
    logic [IDX_W-1:0]     g_ext;
    logic [IDX_W-1:0]     h;
    logic                 hit_hdr;

    logic [glim_pkg::STATUS_W-1:0] exec_status;
    logic [START_W-1:0]            exec_src;
    logic [glim_pkg::DISP_W-1:0]   exec_disp;

    // Range checks and search status
    always_comb
    begin
        disp_limit = {1'b0, active_total_reg} + (IDX_W + 1)'(active_n_reg);
        disp_range = {1'b0, idx_reg} >= disp_limit;
        src_range  = idx_reg >= active_total_reg;
        n_zero     = (active_n_reg == '0);
        sts.need_search = !n_zero &&
            (((cmd_reg == glim_pkg::CMD_MAP_DISP) && !disp_range) ||
             ((cmd_reg == glim_pkg::CMD_MAP_SRC) && !src_range));
        sts.s_done   = (lo_reg >= hi_reg);
        sts.out_free = !out_valid_reg || response.ready;
    end

    // Staging checks
    always_comb
    begin
        load_bad = (staged_n_reg >= SEC_W'(MAX_SECTIONS)) || (scount_reg == '0) ||
                   ({1'b0, sstart_reg} != expect_reg) ||
                   (scount_reg > (staged_total_reg - expect_reg));
        commit_bad = failed_reg ||
                     ((staged_n_reg != '0) && (expect_reg != staged_total_reg));
    end

    // Addresses and search compare
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = SEC_W'(mid_sum >> 1);
        rd_addr = ADDR_W'(SLOT_W'(mid)) +
                  (active_bank_reg ? ADDR_W'(MAX_SECTIONS) : ADDR_W'(0));
        wr_addr = ADDR_W'(SLOT_W'(staged_n_reg)) +
                  (active_bank_reg ? ADDR_W'(0) : ADDR_W'(MAX_SECTIONS));
        if (cmd_reg == glim_pkg::CMD_MAP_DISP)
            pred = ({2'b0, rd_data_reg} + (IDX_W + 1)'(mid)) <= {1'b0, idx_reg};
        else
            pred = {1'b0, rd_data_reg} <= idx_reg;
    end

    // Final group and header position
    always_comb
    begin
        g       = (lo_reg == '0) ? '0 : lo_reg - SEC_W'(1);
        g_ext   = IDX_W'(g);
        h       = {1'b0, st_reg} + g_ext;
        hit_hdr = (idx_reg == h);
    end

    // Result fields of non-search commands
    always_comb
    begin
        exec_status = glim_pkg::STAT_OK;
        exec_src    = '0;
        exec_disp   = '0;
        unique case (cmd_reg)
            glim_pkg::CMD_COMMIT:
                if (commit_bad)
                    exec_status = glim_pkg::STAT_REJECT;
            glim_pkg::CMD_MAP_DISP:
                if (disp_range)
                    exec_status = glim_pkg::STAT_RANGE;
                else
                    exec_src = idx_reg[START_W-1:0];
            glim_pkg::CMD_MAP_SRC:
                if (src_range)
                    exec_status = glim_pkg::STAT_RANGE;
                else
                begin
                    exec_src  = idx_reg[START_W-1:0];
                    exec_disp = idx_reg;
                end
            default:
            begin
            end
        endcase
    end

    // Section start memory
    always_ff @(posedge clk)
    begin
        if (ctl.exec && (cmd_reg == glim_pkg::CMD_LOAD) && !failed_reg && !load_bad)
            mem[wr_addr] <= sstart_reg;
        if (ctl.s_read)
            rd_data_reg <= mem[rd_addr];
    end

    // Table and staging state, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bank_reg  <= 1'b0;
            active_total_reg <= '0;
            active_n_reg     <= '0;
            staged_total_reg <= '0;
            staged_n_reg     <= '0;
            expect_reg       <= '0;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                unique case (cmd_reg)
                    glim_pkg::CMD_BEGIN:
                    begin
                        staged_total_reg <= idx_reg;
                        staged_n_reg     <= '0;
                        expect_reg       <= '0;
                        failed_reg       <= 32'(idx_reg) > 32'(MAX_ROWS);
                    end
                    glim_pkg::CMD_LOAD:
                    begin
                        if (!failed_reg)
                        begin
                            if (load_bad)
                                failed_reg <= 1'b1;
                            else
                            begin
                                staged_n_reg <= staged_n_reg + SEC_W'(1);
                                expect_reg   <= expect_reg + scount_reg;
                            end
                        end
                    end
                    glim_pkg::CMD_COMMIT:
                    begin
                        if (!commit_bad)
                        begin
                            active_bank_reg  <= !active_bank_reg;
                            active_total_reg <= staged_total_reg;
                            active_n_reg     <= staged_n_reg;
                        end
                        // staging closes either way
                        failed_reg <= 1'b1;
                    end
                    glim_pkg::CMD_CLEAR:
                    begin
                        active_total_reg <= '0;
                        active_n_reg     <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (response.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture, search window, results, output payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg    <= req_command;
            idx_reg    <= req_index;
            sstart_reg <= req_start;
            scount_reg <= req_count;
        end

        if (ctl.s_init)
        begin
            lo_reg <= '0;
            hi_reg <= active_n_reg;
            st_reg <= '0;
        end
        else if (ctl.s_step)
        begin
            if (pred)
            begin
                lo_reg <= mid + SEC_W'(1);
                st_reg <= rd_data_reg;
            end
            else
                hi_reg <= mid;
        end

        // Results of non-search commands and of finished searches
        if (ctl.exec)
        begin
            res_status_reg <= exec_status;
            res_hdr_reg    <= 1'b0;
            res_src_reg    <= exec_src;
            res_grp_reg    <= '0;
            res_disp_reg   <= exec_disp;
        end
        else if (ctl.s_finish)
        begin
            res_status_reg <= glim_pkg::STAT_OK;
            res_grp_reg    <= glim_pkg::GROUP_W'(g);
            if (cmd_reg == glim_pkg::CMD_MAP_DISP)
            begin
                res_hdr_reg  <= hit_hdr;
                res_src_reg  <= hit_hdr ? st_reg
                                        : START_W'(idx_reg - g_ext - IDX_W'(1));
                res_disp_reg <= '0;
            end
            else
            begin
                res_hdr_reg  <= 1'b0;
                res_src_reg  <= idx_reg[START_W-1:0];
                res_disp_reg <= idx_reg + g_ext + IDX_W'(1);
            end
        end

        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_hdr_reg    <= res_hdr_reg;
            out_src_reg    <= res_src_reg;
            out_grp_reg    <= res_grp_reg;
            out_disp_reg   <= res_disp_reg;
        end
    end

    assign response.valid            = out_valid_reg;
    assign response.status           = out_status_reg;
    assign response.is_header        = out_hdr_reg;
    assign response.source_row       = out_src_reg;
    assign response.group_number     = out_grp_reg;
    assign response.display_position = out_disp_reg;

endmodule

`default_nettype wire

// ----- rtl/grouped_list_index_mapper.sv -----
// grouped_list_index_mapper: top level, joins controller and datapath.
// Depends on glim_pkg, glim_in_if, glim_out_if, glim_ctrl, glim_dp.
//
//   channel    modport  payload
//   request    sink     command, index, section_start, section_count
//   response   source   status, is_header, source_row, group_number,
//                       display_position
//
// One item at a time. Begin, load, commit, clear, out-of-range and empty-table
// queries go from the execute state through the result register to the output
// register. A table query instead runs a binary search, one registered memory
// read and one compare per step, ceil(log2(n+1)) steps for n active sections,
// then closes the search before its result goes to the output register.
// The next item is accepted once the result sits in the output register.
// Reset clears table and staging; the section memory needs no clearing.
`default_nettype none

module grouped_list_index_mapper #(
    parameter int MAX_SECTIONS = 64,
    parameter int MAX_ROWS     = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    glim_in_if.sink    request,
    glim_out_if.source response
);

    glim_pkg::glim_ctl_t ctl;
    glim_pkg::glim_sts_t sts;

    glim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    glim_dp #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_command (request.command),
        .req_index   (request.index),
        .req_start   (request.section_start),
        .req_count   (request.section_count),
        .ctl         (ctl),
        .sts         (sts),
        .response    (response)
    );

    // A result never overwrites one still waiting in the output register
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> sts.out_free)
        else $error("result loaded while output register busy");

    // No second item is taken while one is in flight
    a_no_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> !request.ready)
        else $error("request ready right after accept");

    // Every compare works on data read in the cycle before
    a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.s_step |-> $past(ctl.s_read))
        else $error("search step without a preceding read");

endmodule

`default_nettype wire

// ----- tb/tb_grouped_list_index_mapper.sv -----
`timescale 1ns / 100ps
// tb_grouped_list_index_mapper: self-checking bench for the grouped list index mapper.
// Depends on glim_pkg, glim_in_if, glim_out_if and the grouped_list_index_mapper RTL.

module tb_grouped_list_index_mapper;

    localparam int CMD_W    = glim_pkg::CMD_W;
    localparam int IDX_W    = glim_pkg::IDX_W;
    localparam int START_W  = glim_pkg::START_W;
    localparam int COUNT_W  = glim_pkg::COUNT_W;
    localparam int STATUS_W = glim_pkg::STATUS_W;
    localparam int GROUP_W  = glim_pkg::GROUP_W;
    localparam int DISP_W   = glim_pkg::DISP_W;

    localparam int MAX_SECTIONS   = 64;
    localparam int MAX_ROWS       = 65536;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int START_MAX      = (1 << START_W) - 1;
    localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
    localparam int RANDOM_ITEMS   = 600;
    localparam int CALM_TAIL      = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    // Spare command codes, decoded as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Ways to spoil a table load
    typedef enum int {
        FLAW_NONE,
        FLAW_ZERO_COUNT,
        FLAW_WRONG_START,
        FLAW_OVERRUN,
        FLAW_SHORT_SUM,
        FLAW_HUGE_TOTAL,
        FLAW_OVERFLOW,
        FLAW_DOUBLE_COMMIT
    } flaw_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_header;
        logic [START_W-1:0]  source_row;
        logic [GROUP_W-1:0]  group_number;
        logic [DISP_W-1:0]   display_position;
    } mapping_t;

    // Shadow copy of the section table; predicts each result and checks it
    class mapping_tracker;
        int       section_table [2*MAX_SECTIONS];
        bit       active_bank;
        int       active_rows;
        int       active_count;
        int       staged_rows;
        int       staged_count;
        int       next_start;
        bit       load_failed;
        mapping_t expected_maps [$];
        int       mismatch_count;

        function new();
            foreach (section_table[i])
                section_table[i] = 0;
            active_bank    = 1'b0;
            active_rows    = 0;
            active_count   = 0;
            staged_rows    = 0;
            staged_count   = 0;
            next_start     = 0;
            load_failed    = 1'b0;
            mismatch_count = 0;
        endfunction

        function int active_base();
            return active_bank ? MAX_SECTIONS : 0;
        endfunction

        // Last section whose start (or header position) is at or below row
        function int find_group(int row, bit headers);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = active_count;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (section_table[active_base() + mid] + (headers ? mid : 0) <= row)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return (lo > 0) ? lo - 1 : 0;
        endfunction

        function mapping_t predict_mapping(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                           logic [START_W-1:0] start,
                                           logic [COUNT_W-1:0] count);
            mapping_t m;
            int       row;
            int       first;
            int       len;
            int       g;
            int       head;
            m     = '0;
            row   = int'(idx);
            first = int'(start);
            len   = int'(count);
            case (cmd)
                glim_pkg::CMD_BEGIN:
                begin
                    staged_rows  = row;
                    staged_count = 0;
                    next_start   = 0;
                    load_failed  = (row > MAX_ROWS);
                end
                glim_pkg::CMD_LOAD:
                begin
                    if (!load_failed)
                    begin
                        if (staged_count >= MAX_SECTIONS || len == 0 || first != next_start ||
                            len > staged_rows - next_start)
                            load_failed = 1'b1;
                        else
                        begin
                            section_table[(active_bank ? 0 : MAX_SECTIONS) + staged_count] = first;
                            staged_count++;
                            next_start += len;
                        end
                    end
                end
                glim_pkg::CMD_COMMIT:
                begin
                    if (load_failed || (staged_count > 0 && next_start != staged_rows))
                        m.status = glim_pkg::STAT_REJECT;
                    else
                    begin
                        active_bank  = !active_bank;
                        active_rows  = staged_rows;
                        active_count = staged_count;
                    end
                    load_failed = 1'b1;
                end
                glim_pkg::CMD_CLEAR:
                begin
                    active_rows  = 0;
                    active_count = 0;
                end
                glim_pkg::CMD_MAP_DISP:
                begin
                    if (row >= active_rows + active_count)
                        m.status = glim_pkg::STAT_RANGE;
                    else if (active_count == 0)
                        m.source_row = START_W'(row);
                    else
                    begin
                        g    = find_group(row, 1'b1);
                        head = section_table[active_base() + g] + g;
                        m.group_number = GROUP_W'(g);
                        if (row == head)
                        begin
                            m.is_header  = 1'b1;
                            m.source_row = START_W'(section_table[active_base() + g]);
                        end
                        else
                            m.source_row =
                                START_W'(section_table[active_base() + g] + row - head - 1);
                    end
                end
                glim_pkg::CMD_MAP_SRC:
                begin
                    if (row >= active_rows)
                        m.status = glim_pkg::STAT_RANGE;
                    else if (active_count == 0)
                    begin
                        m.source_row       = START_W'(row);
                        m.display_position = DISP_W'(row);
                    end
                    else
                    begin
                        g = find_group(row, 1'b0);
                        m.source_row       = START_W'(row);
                        m.group_number     = GROUP_W'(g);
                        m.display_position = DISP_W'(row + g + 1);
                    end
                end
                default:
                    ;
            endcase
            return m;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                   logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
            expected_maps.push_back(predict_mapping(cmd, idx, start, count));
        endfunction

        function void check_result(mapping_t got);
            mapping_t want;
            if (expected_maps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d hdr %0d src %0d grp %0d disp %0d",
                             got.status, got.is_header, got.source_row, got.group_number,
                             got.display_position);
                return;
            end
            want = expected_maps.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("mismatch: expected status %0d hdr %0d src %0d grp %0d disp %0d",
                             want.status, want.is_header, want.source_row,
                             want.group_number, want.display_position);
                    $display("          got      status %0d hdr %0d src %0d grp %0d disp %0d",
                             got.status, got.is_header, got.source_row,
                             got.group_number, got.display_position);
                end
            end
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction

        function int display_rows();
            return active_rows + active_count;
        endfunction

        function int header_row(int g);
            return section_table[active_base() + g] + g;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    glim_in_if  request_bus ();
    glim_out_if response_bus ();

    grouped_list_index_mapper #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .MAX_ROWS     (MAX_ROWS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus),
        .response (response_bus)
    );

    mapping_tracker tracker = new();

    bit calm          = 1'b0;
    bit hold_request  = 1'b0;
    int requests_sent = 0;
    int stall_cycles  = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both channels; watchdog on cycles without any handshake
    always @(posedge clk)
    begin : monitor
        mapping_t got;
        if (rst_n)
        begin
            if (response_bus.valid && response_bus.ready)
            begin
                got.status           = response_bus.status;
                got.is_header        = response_bus.is_header;
                got.source_row       = response_bus.source_row;
                got.group_number     = response_bus.group_number;
                got.display_position = response_bus.display_position;
                tracker.check_result(got);
            end
            if (request_bus.valid && request_bus.ready)
                tracker.note_request(request_bus.command, request_bus.index,
                                     request_bus.section_start, request_bus.section_count);
            if ((request_bus.valid && request_bus.ready) ||
                (response_bus.valid && response_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_grouped_list_index_mapper NOT OK");
                $finish;
            end
        end
    end

    // Result side: random ready bursts, one long hold-off on request
    initial
    begin : receiver
        response_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                response_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                response_bus.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                response_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                response_bus.ready <= 1'b1;
            end
            else
                response_bus.ready <= 1'b1;
        end
    end

    // Offer one item at a falling edge and return once it is accepted
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int idx, input int start,
                             input int count);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            request_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        request_bus.valid         <= 1'b1;
        request_bus.command       <= cmd;
        request_bus.index         <= IDX_W'(idx);
        request_bus.section_start <= START_W'(start);
        request_bus.section_count <= COUNT_W'(count);
        do
            @(posedge clk);
        while (!request_bus.ready);
        if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        request_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Display and source lookups against the active table
    task automatic query_burst(input int n);
        bit [CMD_W-1:0] cmd;
        int             limit;
        int             idx;
        repeat (n)
        begin
            cmd   = $urandom_range(0, 1) ? glim_pkg::CMD_MAP_DISP : glim_pkg::CMD_MAP_SRC;
            limit = (cmd == glim_pkg::CMD_MAP_DISP) ? tracker.display_rows()
                                                    : tracker.active_rows;
            case ($urandom_range(0, 15))
                0: idx = limit + $urandom_range(0, 2);
                1: idx = $urandom_range(limit, IDX_MAX);
                2: idx = 0;
                3: idx = (limit > 0) ? limit - 1 : 0;
                4, 5, 6:
                begin
                    if (cmd == glim_pkg::CMD_MAP_DISP && tracker.active_count > 0)
                    begin
                        idx = tracker.header_row($urandom_range(0, tracker.active_count - 1));
                        idx = idx + $urandom_range(0, 1);
                    end
                    else
                        idx = (limit > 0) ? $urandom_range(0, limit - 1) : 0;
                end
                default: idx = (limit > 0) ? $urandom_range(0, limit - 1) : 0;
            endcase
            send_item(cmd, idx, $urandom_range(0, START_MAX), $urandom_range(0, COUNT_MAX));
        end
    endtask

    // Begin, load sections, commit, then look up; optionally with one flaw
    task automatic build_table(input flaw_t flaw);
        int sections;
        int rows;
        int total;
        int left;
        int hi_c;
        int cap;
        int cnt;
        int start_row;
        int bad_at;
        int first;
        int len;
        case ($urandom_range(0, 9))
            0:       sections = 0;
            7:       sections = $urandom_range(7, 20);
            8:       sections = MAX_SECTIONS;
            9:       sections = $urandom_range(2, 40);
            default: sections = $urandom_range(1, 6);
        endcase
        if (flaw == FLAW_OVERFLOW)
            sections = MAX_SECTIONS + 1;
        if (sections == 0 && (flaw == FLAW_ZERO_COUNT || flaw == FLAW_WRONG_START ||
                              flaw == FLAW_OVERRUN || flaw == FLAW_SHORT_SUM))
            sections = 1;
        if ($urandom_range(0, 7) == 0)
            rows = MAX_ROWS;
        else
            rows = sections + $urandom_range(0, 300);
        if (flaw == FLAW_SHORT_SUM)
            total = rows + $urandom_range(1, 5);
        else if (flaw == FLAW_HUGE_TOTAL)
            total = $urandom_range(MAX_ROWS + 1, IDX_MAX);
        else
            total = rows;
        send_item(glim_pkg::CMD_BEGIN, total, $urandom_range(0, START_MAX),
                  $urandom_range(0, COUNT_MAX));

        start_row = 0;
        left      = rows;
        bad_at    = (sections > 0) ? $urandom_range(0, sections - 1) : 0;
        for (int s = 0; s < sections; s++)
        begin
            if (s == sections - 1)
                cnt = left;
            else
            begin
                hi_c = left - (sections - 1 - s);
                cap  = 2 * left / (sections - s);
                if (cap < 1)
                    cap = 1;
                if (hi_c > cap)
                    hi_c = cap;
                cnt = $urandom_range(1, hi_c);
            end
            first = start_row;
            len   = cnt;
            if (s == bad_at)
            begin
                case (flaw)
                    FLAW_ZERO_COUNT:  len = 0;
                    FLAW_WRONG_START: first = start_row + $urandom_range(1, 3);
                    FLAW_OVERRUN:     len = left + 1;
                    default:          ;
                endcase
            end
            send_item(glim_pkg::CMD_LOAD, $urandom_range(0, IDX_MAX), first, len);
            start_row += cnt;
            left      -= cnt;
        end

        send_item(glim_pkg::CMD_COMMIT, $urandom_range(0, IDX_MAX),
                  $urandom_range(0, START_MAX), $urandom_range(0, COUNT_MAX));
        if (flaw == FLAW_DOUBLE_COMMIT)
            send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        query_burst($urandom_range(4, 16));
    endtask

    initial
    begin : stimulus
        bit hold_done;
        bit drain_done;
        int pick;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n                     = 1'b0;
        request_bus.valid         = 1'b0;
        request_bus.command       = glim_pkg::CMD_BEGIN;
        request_bus.index         = '0;
        request_bus.section_start = '0;
        request_bus.section_count = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty staging commit, limits, failures, spare code, clear
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(glim_pkg::CMD_MAP_DISP, 0, 0, 0);
        send_item(CMD_SPARE_LO, IDX_MAX, START_MAX, COUNT_MAX);
        send_item(glim_pkg::CMD_BEGIN, IDX_MAX, 0, 0);
        send_item(glim_pkg::CMD_LOAD, 0, 0, 5);
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(glim_pkg::CMD_BEGIN, MAX_ROWS, 0, 0);
        send_item(glim_pkg::CMD_LOAD, 0, 0, MAX_ROWS);
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(glim_pkg::CMD_MAP_DISP, 0, 0, 0);
        send_item(glim_pkg::CMD_MAP_DISP, MAX_ROWS, 0, 0);
        send_item(glim_pkg::CMD_MAP_DISP, IDX_MAX, 0, 0);
        send_item(glim_pkg::CMD_MAP_SRC, MAX_ROWS - 1, 0, 0);
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(glim_pkg::CMD_LOAD, 0, 0, 1);
        send_item(glim_pkg::CMD_BEGIN, 5, 0, 0);
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(glim_pkg::CMD_MAP_DISP, 4, 0, 0);
        send_item(glim_pkg::CMD_MAP_SRC, 5, 0, 0);
        send_item(glim_pkg::CMD_CLEAR, 0, 0, 0);
        send_item(glim_pkg::CMD_MAP_SRC, 0, 0, 0);
        send_item(glim_pkg::CMD_BEGIN, 10, 0, 0);
        send_item(glim_pkg::CMD_LOAD, 0, 0, 0);
        send_item(glim_pkg::CMD_COMMIT, 0, 0, 0);
        send_item(CMD_SPARE_HI, 0, 0, 0);

        // Random: mostly clean table builds with lookups, some broken, some noise
        requests_sent = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            calm = (requests_sent >= RANDOM_ITEMS - CALM_TAIL);
            if (!hold_done && requests_sent >= 200)
            begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                query_burst(8);
            end
            else if (!drain_done && requests_sent >= 350)
            begin
                drain_done = 1'b1;
                wait_for_results();
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    build_table(FLAW_NONE);
                else if (pick < 72)
                    build_table(flaw_t'($urandom_range(FLAW_ZERO_COUNT, FLAW_DOUBLE_COMMIT)));
                else if (pick < 82)
                    send_item(CMD_W'($urandom_range(0, 7)), $urandom_range(0, IDX_MAX),
                              $urandom_range(0, START_MAX), $urandom_range(0, COUNT_MAX));
                else if (pick < 94)
                    query_burst($urandom_range(3, 10));
                else
                begin
                    send_item(glim_pkg::CMD_CLEAR, $urandom_range(0, IDX_MAX), 0, 0);
                    query_burst(3);
                end
            end
        end

        // Drain and settle
        request_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("tb_grouped_list_index_mapper OK");
        else
            $display("tb_grouped_list_index_mapper NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/glim_pkg.sv
rtl/glim_in_if.sv
rtl/glim_out_if.sv
rtl/glim_ctrl.sv
rtl/glim_dp.sv
rtl/grouped_list_index_mapper.sv
tb/tb_grouped_list_index_mapper.sv
